### rtl/multibrot_cubic_escape_time_unit_defines.svh
// Assertion macros of the multibrot cubic escape-time RTL, used by the sequencer (mbc_ctrl).
`ifndef MULTIBROT_CUBIC_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MULTIBROT_CUBIC_ESCAPE_TIME_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mbc assertion failed");
`define MBC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("mbc assertion failed");
`else
`define MBC_ASSERT(lbl, clk, rst_n, prop)
`define MBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/mbc_pkg.sv
// Package: types and constants of the multibrot cubic escape-time unit.
`timescale 1ns / 1ps
`default_nettype none
package mbc_pkg;

	localparam int C_W       = 30;
	localparam int X_W       = 32;
	localparam int SQ_W      = 63;
	localparam int SQ_FL_W   = 31;
	localparam int FRAC_BITS = 26;
	localparam int COUNT_W   = 9;
	localparam int COUNT_SAT = 511;
	localparam int ITER_LIMIT_DEF = 255;

	// 4.0 in Q.52
	localparam logic [SQ_W:0] ESC_LIMIT = 64'h0040_0000_0000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQ,
		ST_STEP,
		ST_HOLD
	} mbc_state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic step;
	} lane_ctl_t;

endpackage
`default_nettype wire

### rtl/multibrot_cubic_escape_time_unit.sv
// Top level of the multibrot cubic escape-time unit: two lane cells and the sequencer.
// Usage:
//  - Input channel: in_valid / in_stall with c_real, c_imag (Q3.26, signed).
//    A point is taken when in_valid is high and in_stall is low; in_stall is
//    low only while no point is being iterated.
//  - Output channel: out_valid / out_stall with iteration_count (1 to
//    ITER_LIMIT+1, held at 511 if larger).
//  - Each iteration has two steps: the lanes square z in ST_SQ and form
//    the cubic update in ST_STEP, as the two multiplies of a lane depend on
//    each other. One point is in work at a time: the next can be taken in
//    the cycle after the result is written.
//  - The result register parts the channels: a new point is taken while the
//    previous result still waits. If the receiver stalls when the next result
//    is ready, the sequencer holds it and takes no new point until it is free.
//  - Reset (arst_n low) empties the sequencer, the lanes and the result
//    register; there is nothing to configure.
`timescale 1ns / 1ps
`default_nettype none
module multibrot_cubic_escape_time_unit #(
	parameter int ITER_LIMIT = mbc_pkg::ITER_LIMIT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [mbc_pkg::C_W-1:0]     c_real,
	input  wire logic signed [mbc_pkg::C_W-1:0]     c_imag,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [mbc_pkg::COUNT_W-1:0]             iteration_count
);
	import mbc_pkg::*;

	lane_ctl_t            lane_ctl;
	logic [SQ_FL_W-1:0]   re_sq_fl;
	logic [SQ_FL_W-1:0]   im_sq_fl;
	logic [SQ_W-1:0]      re_sq;
	logic [SQ_W-1:0]      im_sq;

	// real lane: re*(a2 - 3*b2) + c_real
	mbc_lane u_lane_re (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.flip     (1'b0),
		.c_in     (c_real),
		.nb_sq_fl (im_sq_fl),
		.sq_fl    (re_sq_fl),
		.sq       (re_sq)
	);

	// imaginary lane: im*(3*a2 - b2) + c_imag
	mbc_lane u_lane_im (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.flip     (1'b1),
		.c_in     (c_imag),
		.nb_sq_fl (re_sq_fl),
		.sq_fl    (im_sq_fl),
		.sq       (im_sq)
	);

	mbc_ctrl #(
		.ITER_LIMIT (ITER_LIMIT)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.iteration_count (iteration_count),
		.sq_re           (re_sq),
		.sq_im           (im_sq),
		.lane_ctl        (lane_ctl)
	);

endmodule
`default_nettype wire

### rtl/mbc_lane.sv
// One lane cell: holds one component of z, squares it, then forms its cubic update.
`timescale 1ns / 1ps
`default_nettype none
module mbc_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mbc_pkg::lane_ctl_t                  ctl,
	input  wire logic                                flip,
	input  wire logic signed [mbc_pkg::C_W-1:0]      c_in,
	input  wire logic        [mbc_pkg::SQ_FL_W-1:0]  nb_sq_fl,
	output logic             [mbc_pkg::SQ_FL_W-1:0]  sq_fl,
	output logic             [mbc_pkg::SQ_W-1:0]     sq
);
	import mbc_pkg::*;

	logic signed [X_W-1:0]         x_q;
	logic signed [C_W-1:0]         c_q;
	logic        [SQ_W-1:0]        sq_q;
	logic signed [2*X_W-1:0]       sq_full;
	logic        [SQ_FL_W+1:0]     own_ext;
	logic        [SQ_FL_W+1:0]     nb_ext;
	logic        [SQ_FL_W+1:0]     nb_x3;
	logic        [SQ_FL_W+1:0]     coeff_ext;
	logic signed [SQ_FL_W-1:0]     coeff;
	logic signed [X_W+SQ_FL_W-1:0] prod;
	logic signed [X_W-1:0]         x_next;

	assign sq_full = x_q * x_q;
	assign sq_fl   = sq_q[FRAC_BITS+SQ_FL_W-1:FRAC_BITS];
	assign sq      = sq_q;

	assign own_ext   = {2'b00, sq_fl};
	assign nb_ext    = {2'b00, nb_sq_fl};
	assign nb_x3     = nb_ext + (nb_ext << 1);
	assign coeff_ext = flip ? (nb_x3 - own_ext) : (own_ext - nb_x3);
	assign coeff     = coeff_ext[SQ_FL_W-1:0];
	assign prod      = x_q * coeff;
	// arithmetic shift gives floor
	assign x_next    = prod[FRAC_BITS+X_W-1:FRAC_BITS]
		+ {{(X_W-C_W){c_q[C_W-1]}}, c_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			c_q  <= '0;
			sq_q <= '0;
		end else begin
			if (ctl.load) begin
				x_q <= '0;
				c_q <= c_in;
			end else if (ctl.step) begin
				x_q <= x_next;
			end
			if (ctl.square) begin
				sq_q <= sq_full[SQ_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### rtl/mbc_ctrl.sv
// Sequencer: escape test, iteration count, handshakes and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "multibrot_cubic_escape_time_unit_defines.svh"
module mbc_ctrl #(
	parameter int ITER_LIMIT = mbc_pkg::ITER_LIMIT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [mbc_pkg::COUNT_W-1:0]          iteration_count,
	input  wire logic [mbc_pkg::SQ_W-1:0]        sq_re,
	input  wire logic [mbc_pkg::SQ_W-1:0]        sq_im,
	output mbc_pkg::lane_ctl_t                   lane_ctl
);
	import mbc_pkg::*;

	localparam int CNT_NEED = $clog2(ITER_LIMIT + 2);
	localparam int CNT_W    = (CNT_NEED > COUNT_W) ? CNT_NEED : COUNT_W;

	mbc_state_t           state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   iteration_count_q;
	logic [SQ_W:0]        mag;
	logic                 escaped;
	logic                 slot_free;
	logic                 res_wr;
	logic [COUNT_W-1:0]   cnt_sat;

	assign mag       = {1'b0, sq_re} + {1'b0, sq_im};
	assign escaped   = (mag > ESC_LIMIT) || (cnt_q > CNT_W'(ITER_LIMIT));
	assign slot_free = !out_valid_q || !out_stall;
	assign cnt_sat   = (cnt_q > CNT_W'(COUNT_SAT)) ? COUNT_W'(COUNT_SAT)
		: cnt_q[COUNT_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SQ;
			end
			ST_SQ: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (!escaped)      state_d = ST_SQ;
				else if (slot_free) state_d = ST_IDLE;
				else               state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		lane_ctl = '0;
		res_wr   = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				lane_ctl.load = in_valid;
			end
			ST_SQ: begin
				lane_ctl.square = 1'b1;
			end
			ST_STEP: begin
				lane_ctl.step = !escaped;
				res_wr        = escaped && slot_free;
			end
			ST_HOLD: begin
				res_wr = slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (lane_ctl.load) cnt_q <= '0;
			else if (lane_ctl.step) cnt_q <= cnt_q + 1'b1;
			if (res_wr) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) iteration_count_q <= cnt_sat;
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = iteration_count_q;

	`MBC_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_q <= CNT_W'(ITER_LIMIT + 1))
	`MBC_ASSERT(a_accept_starts, clk, arst_n, (in_valid && !in_stall) |=> state_q == ST_SQ)
	`MBC_ASSERT(a_step_counts, clk, arst_n, lane_ctl.step |=> cnt_q == $past(cnt_q) + 1'b1)
	`MBC_ASSERT(a_result_bound, clk, arst_n, res_wr |=> iteration_count_q <= COUNT_W'(COUNT_SAT))
	`MBC_ASSERT(a_no_overwrite, clk, arst_n, (out_valid_q && out_stall) |-> !res_wr)

endmodule
`default_nettype wire
